/* src/psfq_pkg.sv */
`default_nettype none

package psfq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_SORT    = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // one stored entry, priority in the upper half
  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request toward the entry memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // ring buffer successor of a slot
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] n;
    n = (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

/* src/priority_sortable_fifo_unit.sv */
`default_nettype none

// Bounded queue of (data, priority) entries held in a ring buffer of
// QUEUE_DEPTH places in one single-port-write, registered-read memory.
// Each transaction carries an opcode: enqueue appends at the tail, dequeue
// removes the head, sort reorders the stored entries with an exchange sort
// so priorities end non-increasing from head to tail. Every transaction
// gives exactly one result transaction with status and occupancy.
// Enqueue, rejected operations and sorts of fewer than two entries register
// their result when taken; a dequeue waits in T_DEQ for the registered memory
// read. A sort holds the input until the sequencer is done: for each outer
// position the sequencer reads the entry, then walks every position at one
// memory read and at most one write per cycle, then writes the held entry back.
// A new transaction is taken while the previous result still waits, as long
// as that result leaves in the same cycle.

module priority_sortable_fifo_unit
  import psfq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // data_in, priority_in
  input  wire logic [1:0]  s_axis_tuser,   // opcode
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [71:0] m_axis_tdata,   // out_data, out_priority, occupancy, zero fill
  output      logic [1:0]  m_axis_tuser    // status
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_DEQ,
    T_SORT
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic signed [DATA_W-1:0] out_prio_q, out_prio_d;
  logic [ST_W-1:0]          out_st_q, out_st_d;
  logic [OCC_W-1:0]         out_occ_q, out_occ_d;

  logic                     accept;
  logic [OP_W-1:0]          opcode;
  entry_t                   in_entry;
  ram_req_t                 ctrl_req, sort_req, ram_req;
  entry_t                   rdata;
  logic [ENTRY_W-1:0]       rdata_raw;
  logic                     sort_start, sort_done;

  assign opcode        = s_axis_tuser;
  assign in_entry.data = s_axis_tdata[31:0];
  assign in_entry.prio = s_axis_tdata[63:32];

  assign s_axis_tready = (state_q == T_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // queue control and result register
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_prio_d  = out_prio_q;
    out_st_d    = out_st_q;
    out_occ_d   = out_occ_q;
    ctrl_req    = '0;
    ctrl_req.raddr = head_q;
    sort_start  = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          out_data_d = '0;
          out_prio_d = '0;
          out_st_d   = ST_DONE;
          out_occ_d  = OCC_W'(count_q);
          case (opcode)
            OP_ENQUEUE: begin
              out_valid_d = 1'b1;
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                out_st_d = ST_FULL;
              end else begin
                ctrl_req.we    = 1'b1;
                ctrl_req.waddr = tail_q;
                ctrl_req.wdata = in_entry;
                tail_d         = next_slot(tail_q);
                count_d        = count_q + 1'b1;
                out_occ_d      = OCC_W'(count_q + 1'b1);
              end
            end
            OP_DEQUEUE: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_st_d    = ST_EMPTY;
              end else begin
                head_d  = next_slot(head_q);
                count_d = count_q - 1'b1;
                state_d = T_DEQ;
              end
            end
            OP_SORT: begin
              if (count_q < CNT_W'(2)) begin
                out_valid_d = 1'b1;
              end else begin
                sort_start = 1'b1;
                state_d    = T_SORT;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      T_DEQ: begin
        out_valid_d = 1'b1;
        out_data_d  = rdata.data;
        out_prio_d  = rdata.prio;
        out_occ_d   = OCC_W'(count_q);
        state_d     = T_IDLE;
      end
      T_SORT: begin
        if (sort_done) begin
          out_valid_d = 1'b1;
          out_occ_d   = OCC_W'(count_q);
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // control state and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_prio_q  <= '0;
      out_st_q    <= ST_DONE;
      out_occ_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_prio_q  <= out_prio_d;
      out_st_q    <= out_st_d;
      out_occ_q   <= out_occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_prio_q, out_data_q};
  assign m_axis_tuser  = out_st_q;

  // sort sequencer owns the memory while sorting
  psfq_sorter u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sort_start),
    .head_i  (head_q),
    .count_i (count_q),
    .rdata_i (rdata),
    .req_o   (sort_req),
    .done_o  (sort_done)
  );

  assign ram_req = (state_q == T_SORT) ? sort_req : ctrl_req;

  psfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = rdata_raw;

  // checks
  logic [ADDR_W:0] tail_sum;
  logic [ADDR_W:0] tail_exp;
  assign tail_sum = {1'b0, head_q} + (ADDR_W + 1)'(count_q);
  assign tail_exp = (tail_sum >= (ADDR_W + 1)'(QUEUE_DEPTH))
                    ? tail_sum - (ADDR_W + 1)'(QUEUE_DEPTH) : tail_sum;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_tail_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(QUEUE_DEPTH)) || (tail_q == tail_exp[ADDR_W-1:0]))
    else $error("tail pointer out of step with head and count");

  a_done_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_done |-> (state_q == T_SORT))
    else $error("sort finished outside a sort transaction");

  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_DEQ) |=> out_valid_q)
    else $error("dequeue gave no result");

  a_sort_keeps_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_SORT) |=> $stable(count_q) && $stable(head_q))
    else $error("queue pointers moved during sort");

endmodule

`default_nettype wire

/* src/psfq_ram.sv */
`default_nettype none

module psfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/psfq_sorter.sv */
`default_nettype none

module psfq_sorter
  import psfq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] head_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire entry_t            rdata_i,
  output      ram_req_t          req_o,
  output      logic              done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_I,
    S_GET_I,
    S_CMP,
    S_WB
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d;
  logic [ADDR_W-1:0] pi_q, pi_d, pj_q, pj_d;
  entry_t            cur_q, cur_d;
  logic [CNT_W-1:0]  last;
  logic              swap;

  assign last = count_i - 1'b1;

  // entry i is held in cur_q; it never swaps with itself
  assign swap = (j_q != i_q) && (cur_q.prio > rdata_i.prio);

  // exchange sort sequencer, one inner step per cycle
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    pi_d      = pi_q;
    pj_d      = pj_q;
    cur_d     = cur_q;
    req_o     = '0;
    req_o.raddr = pi_q;
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pi_d    = head_i;
          i_d     = '0;
          state_d = S_RD_I;
        end
      end
      S_RD_I: begin
        req_o.raddr = pi_q;
        state_d     = S_GET_I;
      end
      S_GET_I: begin
        cur_d       = rdata_i;
        pj_d        = head_i;
        j_d         = '0;
        req_o.raddr = head_i;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (swap) begin
          req_o.we    = 1'b1;
          req_o.waddr = pj_q;
          req_o.wdata = cur_q;
          cur_d       = rdata_i;
        end
        req_o.raddr = next_slot(pj_q);
        if (j_q == last) begin
          state_d = S_WB;
        end else begin
          j_d  = j_q + 1'b1;
          pj_d = next_slot(pj_q);
        end
      end
      S_WB: begin
        req_o.we    = 1'b1;
        req_o.waddr = pi_q;
        req_o.wdata = cur_q;
        if (i_q == last) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          pi_d    = next_slot(pi_q);
          state_d = S_RD_I;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state, walk registers and held entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      pi_q    <= '0;
      pj_q    <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pi_q    <= pi_d;
      pj_q    <= pj_d;
      cur_q   <= cur_d;
    end
  end

endmodule

`default_nettype wire
